// ===== design/ttg_pkg.sv =====
package ttg_pkg;

   // field widths
   localparam int PAD_IN_WIDTH = 16;
   localparam int TIME_WIDTH = 32;
   localparam int THRESH_WIDTH = 16;
   localparam int MASK_WIDTH = 16;
   localparam int REQ_DATA_WIDTH = PAD_IN_WIDTH + TIME_WIDTH;
   localparam int RSP_DATA_WIDTH = 3 * MASK_WIDTH;
   localparam int CSR_INDEX_WIDTH = 2;

   // default pad count
   localparam int PAD_COUNT_DEFAULT = 16;

   // threshold reset values
   localparam logic [THRESH_WIDTH-1:0] SHORT_TAP_RESET = 16'd200;
   localparam logic [THRESH_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;
   localparam logic [THRESH_WIDTH-1:0] DOUBLE_TAP_RESET = 16'd300;

   // register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SHORT_TAP  = 2'd0,
      CSR_LONG_PRESS = 2'd1,
      CSR_DOUBLE_TAP = 2'd2
   } csr_index_type;

   // thresholds shared by all lanes
   typedef struct packed {
      logic [THRESH_WIDTH-1:0] short_tap_ms;
      logic [THRESH_WIDTH-1:0] long_press_ms;
      logic [THRESH_WIDTH-1:0] double_tap_ms;
   } thresholds_type;

   // events one lane reports for the current word
   typedef struct packed {
      logic single_tap;
      logic double_tap;
      logic long_press;
   } lane_event_type;

endpackage

// ===== design/ttg_lane.sv =====
module ttg_lane (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic                                 touched,
   input  logic [ttg_pkg::TIME_WIDTH-1:0]       time_ms,
   input  ttg_pkg::thresholds_type              thresholds,
   output ttg_pkg::lane_event_type              lane_event
);
   import ttg_pkg::*;

   logic                  held_ff, held_in;
   logic [TIME_WIDTH-1:0] press_start_ff, press_start_in;
   logic [TIME_WIDTH-1:0] last_tap_ff, last_tap_in;

   logic [TIME_WIDTH-1:0] held_for;
   logic [TIME_WIDTH-1:0] since_tap;
   logic                  release_now;
   logic                  tap_now;
   logic                  double_now;

   // elapsed times, wrapping modulo 2^32
   assign held_for = time_ms - press_start_ff;
   assign since_tap = time_ms - last_tap_ff;

   // classification of a release
   assign release_now = !touched && held_ff;
   assign tap_now = release_now &&
                    (held_for < {{(TIME_WIDTH-THRESH_WIDTH){1'b0}}, thresholds.short_tap_ms});
   assign double_now = since_tap <
                       {{(TIME_WIDTH-THRESH_WIDTH){1'b0}}, thresholds.double_tap_ms};

   assign lane_event.single_tap = tap_now && !double_now;
   assign lane_event.double_tap = tap_now && double_now;
   assign lane_event.long_press = release_now && !tap_now &&
      (held_for >= {{(TIME_WIDTH-THRESH_WIDTH){1'b0}}, thresholds.long_press_ms});

   // next pad state
   always_comb begin
      held_in = held_ff;
      press_start_in = press_start_ff;
      last_tap_in = last_tap_ff;
      if (accept) begin
         if (touched && !held_ff) begin
            held_in = 1'b1;
            press_start_in = time_ms;
         end else if (release_now) begin
            held_in = 1'b0;
         end
         if (tap_now) begin
            last_tap_in = time_ms;
         end
      end
   end

   // pad state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
         last_tap_ff <= '0;
      end else begin
         held_ff <= held_in;
         last_tap_ff <= last_tap_in;
      end
   end

   // press start is only read while held
   always_ff @(posedge clock) begin
      press_start_ff <= press_start_in;
   end

endmodule

// ===== design/ttg_merge.sv =====
module ttg_merge #(
   parameter int PAD_COUNT = ttg_pkg::PAD_COUNT_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     accept,
   input  ttg_pkg::lane_event_type [PAD_COUNT-1:0]  lane_events,
   output logic                                     in_ready,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // single_tap_mask[15:0], double_tap_mask[31:16], long_press_mask[47:32]
   output logic [ttg_pkg::RSP_DATA_WIDTH-1:0]       rsp_tdata
);
   import ttg_pkg::*;

   logic                      valid_ff, valid_in;
   logic [RSP_DATA_WIDTH-1:0] data_ff, data_in;
   logic [MASK_WIDTH-1:0]     single_mask;
   logic [MASK_WIDTH-1:0]     double_mask;
   logic [MASK_WIDTH-1:0]     long_mask;

   // gather lane events into masks, pads above the mask width are dropped
   for (genvar j = 0; j < MASK_WIDTH; j++) begin : g_bit
      if (j < PAD_COUNT) begin : g_pad
         assign single_mask[j] = lane_events[j].single_tap;
         assign double_mask[j] = lane_events[j].double_tap;
         assign long_mask[j] = lane_events[j].long_press;
      end else begin : g_none
         assign single_mask[j] = 1'b0;
         assign double_mask[j] = 1'b0;
         assign long_mask[j] = 1'b0;
      end
   end

   // output register refills in the cycle its word is taken
   assign in_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in = data_ff;
      if (accept) begin
         valid_in = 1'b1;
         data_in = {long_mask, double_mask, single_mask};
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = data_ff;

endmodule

// ===== design/touch_tap_gesture_classifier.sv =====
// a result word appears in the cycle after its input word is accepted
// throughput: one word per cycle while rsp_tready is high, set by the per-pad lanes and one output register
// req_tready stays high while the output register is empty or being taken
// reset: synchronous, active high; clears held flags, last tap times and the
// output valid, and restores the default thresholds
module touch_tap_gesture_classifier #(
   parameter int PAD_COUNT = ttg_pkg::PAD_COUNT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // pad_touched[15:0], time_ms[47:16]
   input  logic [ttg_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // single_tap_mask[15:0], double_tap_mask[31:16], long_press_mask[47:32]
   output logic [ttg_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ttg_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [ttg_pkg::THRESH_WIDTH-1:0]     csr_data
);
   import ttg_pkg::*;

   logic                              accept;
   logic [PAD_IN_WIDTH-1:0]           pad_touched;
   logic [TIME_WIDTH-1:0]             time_ms;
   thresholds_type                    thresholds_ff, thresholds_in;
   lane_event_type [PAD_COUNT-1:0]    lane_events;

   // unpack the input word
   assign pad_touched = req_tdata[PAD_IN_WIDTH-1:0];
   assign time_ms = req_tdata[PAD_IN_WIDTH +: TIME_WIDTH];
   assign accept = req_tvalid && req_tready;

   // threshold registers
   assign csr_ready = 1'b1;

   always_comb begin
      thresholds_in = thresholds_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SHORT_TAP:  thresholds_in.short_tap_ms = csr_data;
            CSR_LONG_PRESS: thresholds_in.long_press_ms = csr_data;
            CSR_DOUBLE_TAP: thresholds_in.double_tap_ms = csr_data;
            default:        thresholds_in = thresholds_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresholds_ff.short_tap_ms <= SHORT_TAP_RESET;
         thresholds_ff.long_press_ms <= LONG_PRESS_RESET;
         thresholds_ff.double_tap_ms <= DOUBLE_TAP_RESET;
      end else begin
         thresholds_ff <= thresholds_in;
      end
   end

   // one lane per pad, pads beyond the input width never see a touch
   for (genvar i = 0; i < PAD_COUNT; i++) begin : g_lane
      logic touched;
      if (i < PAD_IN_WIDTH) begin : g_in
         assign touched = pad_touched[i];
      end else begin : g_idle
         assign touched = 1'b0;
      end

      ttg_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .accept     (accept),
         .touched    (touched),
         .time_ms    (time_ms),
         .thresholds (thresholds_ff),
         .lane_event (lane_events[i])
      );
   end

   // merge lane events into the result word
   ttg_merge #(
      .PAD_COUNT (PAD_COUNT)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .lane_events (lane_events),
      .in_ready    (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ===== bench/gesture_checker.sv =====
`timescale 1ns / 100ps

module gesture_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   // pad_touched[15:0], time_ms[47:16]
   input  logic [ttg_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // single_tap_mask[15:0], double_tap_mask[31:16], long_press_mask[47:32]
   input  logic [ttg_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [ttg_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [ttg_pkg::THRESH_WIDTH-1:0]     csr_data,
   output int                                   mismatch_count,
   output int                                   outstanding
);
   import ttg_pkg::*;

   localparam int PADS = PAD_IN_WIDTH;

   // one result word, last field in the lowest bits
   typedef struct packed {
      logic [MASK_WIDTH-1:0] long_press;
      logic [MASK_WIDTH-1:0] double_tap;
      logic [MASK_WIDTH-1:0] single_tap;
   } gesture_word_type;

   thresholds_type        limits;
   logic                  pad_held [PADS];
   logic [TIME_WIDTH-1:0] press_start [PADS];
   logic [TIME_WIDTH-1:0] last_tap [PADS];
   gesture_word_type      expected_gestures [$];

   // per-pad press tracking and release classification for one scan
   function automatic gesture_word_type classify_scan(input logic [PAD_IN_WIDTH-1:0] touched,
                                                      input logic [TIME_WIDTH-1:0] now);
      gesture_word_type      g;
      logic [TIME_WIDTH-1:0] held_for;
      logic [TIME_WIDTH-1:0] since_tap;
      g = '0;
      for (int i = 0; i < PADS; i++) begin
         if (touched[i]) begin
            // a press while already held keeps its start time
            if (!pad_held[i]) begin
               pad_held[i] = 1'b1;
               press_start[i] = now;
            end
         end else if (pad_held[i]) begin
            held_for = now - press_start[i];
            since_tap = now - last_tap[i];
            // the tap test goes first, so it wins when thresholds overlap
            if (held_for < limits.short_tap_ms) begin
               if (since_tap < limits.double_tap_ms) begin
                  g.double_tap[i] = 1'b1;
               end else begin
                  g.single_tap[i] = 1'b1;
               end
               last_tap[i] = now;
            end else if (held_for >= limits.long_press_ms) begin
               g.long_press[i] = 1'b1;
            end
            pad_held[i] = 1'b0;
            press_start[i] = '0;
         end
      end
      return g;
   endfunction

   // report one field of a result word
   task automatic compare_field(input string name, input logic [MASK_WIDTH-1:0] want,
                                input logic [MASK_WIDTH-1:0] got);
      if (got !== want) begin
         $error("%s expected %h got %h", name, want, got);
         mismatch_count++;
      end
   endtask

   // watch all three channels at each rising edge
   always @(posedge clock) begin : monitor
      gesture_word_type got;
      gesture_word_type want;
      if (reset) begin
         limits.short_tap_ms = SHORT_TAP_RESET;
         limits.long_press_ms = LONG_PRESS_RESET;
         limits.double_tap_ms = DOUBLE_TAP_RESET;
         for (int i = 0; i < PADS; i++) begin
            pad_held[i] = 1'b0;
            press_start[i] = '0;
            last_tap[i] = '0;
         end
         expected_gestures.delete();
         mismatch_count = 0;
      end else begin
         // result words come from earlier scans, so check them first
         if (rsp_tvalid && rsp_tready) begin
            got = gesture_word_type'(rsp_tdata);
            if (expected_gestures.size() == 0) begin
               $error("result word %h with no scan waiting", got);
               mismatch_count++;
            end else begin
               want = expected_gestures.pop_front();
               compare_field("single_tap_mask", want.single_tap, got.single_tap);
               compare_field("double_tap_mask", want.double_tap, got.double_tap);
               compare_field("long_press_mask", want.long_press, got.long_press);
            end
         end
         // threshold writes, unknown indexes are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_SHORT_TAP: begin
                  limits.short_tap_ms = csr_data;
               end
               CSR_LONG_PRESS: begin
                  limits.long_press_ms = csr_data;
               end
               CSR_DOUBLE_TAP: begin
                  limits.double_tap_ms = csr_data;
               end
               default: begin
               end
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_gestures.push_back(classify_scan(req_tdata[PAD_IN_WIDTH-1:0],
                                                      req_tdata[REQ_DATA_WIDTH-1:PAD_IN_WIDTH]));
         end
      end
      outstanding = expected_gestures.size();
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import ttg_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 4000;
   localparam int HOLD_OFF_CYCLES = 300;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [REQ_DATA_WIDTH-1:0]   req_tdata;
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic [RSP_DATA_WIDTH-1:0]   rsp_tdata;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index;
   logic [THRESH_WIDTH-1:0]     csr_data;

   int                          failures;
   int                          pending_words;
   bit                          stall_request = 1'b0;
   int                          source_calm = 0;
   int                          sink_calm = 0;
   logic [PAD_IN_WIDTH-1:0]     pads_now = '0;
   logic [TIME_WIDTH-1:0]       now_ms = '0;

   touch_tap_gesture_classifier i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   gesture_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (failures),
      .outstanding    (pending_words)
   );

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   // idle cycles before a word, with runs of back-to-back words
   function automatic int draw_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 11) == 0) begin
         calm_left = $urandom_range(8, 40);
      end
      return $urandom_range(0, 17);
   endfunction

   // offer one scan word and wait until it is taken
   task automatic send_scan(input logic [PAD_IN_WIDTH-1:0] pads,
                            input logic [TIME_WIDTH-1:0] stamp);
      int gap;
      gap = draw_gap(source_calm);
      repeat (gap) @(negedge clock) req_tvalid <= 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {stamp, pads};
      do @(posedge clock); while (!req_tready);
   endtask

   // one threshold write
   task automatic write_threshold(input logic [CSR_INDEX_WIDTH-1:0] index,
                                  input logic [THRESH_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   // wait until every result word is back, then let the pipeline drain
   task automatic settle();
      @(negedge clock) req_tvalid <= 1'b0;
      wait (pending_words == 0);
      repeat (3) @(posedge clock);
   endtask

   // random scans: pads mostly toggle a few at a time, time mostly steps near
   // the thresholds, with occasional jumps that wrap or run backwards
   task automatic run_phase(input logic [THRESH_WIDTH-1:0] short_ms,
                            input logic [THRESH_WIDTH-1:0] long_ms,
                            input logic [THRESH_WIDTH-1:0] double_ms,
                            input int count, input bit squeeze);
      int scale;
      int stretch;
      int pick;
      write_threshold(CSR_SHORT_TAP, short_ms);
      write_threshold(CSR_LONG_PRESS, long_ms);
      write_threshold(CSR_DOUBLE_TAP, double_ms);
      scale = (int'(short_ms) + int'(double_ms)) / 3 + 2;
      stretch = int'(long_ms) + int'(long_ms) / 2 + 2;
      if (squeeze) begin
         stall_request = 1'b1;
      end
      repeat (count) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5) begin
            now_ms += $urandom_range(0, scale);
         end else if (pick <= 7) begin
            now_ms += $urandom_range(0, stretch);
         end else if (pick == 8) begin
            now_ms += $urandom;
         end
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            pads_now = PAD_IN_WIDTH'($urandom);
         end else if (pick <= 5) begin
            pads_now ^= PAD_IN_WIDTH'($urandom & $urandom);
         end else begin
            pads_now ^= PAD_IN_WIDTH'($urandom);
         end
         send_scan(pads_now, now_ms);
      end
      settle();
   endtask

   // result side with random stalls and one long hold-off on request
   initial begin : result_sink
      int gap;
      rsp_tready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (stall_request) begin
            stall_request = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock) rsp_tready <= 1'b0;
         end
         gap = draw_gap(sink_calm);
         repeat (gap) @(negedge clock) rsp_tready <= 1'b0;
         @(negedge clock) rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // end the run if nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Simulation FAILED");
      $finish;
   end

   // stimulus and verdict
   initial begin : stimulus
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = CSR_SHORT_TAP;
      csr_data = '0;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // unknown index must leave the defaults in place
      write_threshold(CSR_UNUSED, THRESH_WIDTH'($urandom));

      // first tap after reset falls inside the double window
      send_scan(16'h0001, 32'd10);
      send_scan(16'h0000, 32'd50);
      // press while held keeps the start, then long press on every pad
      send_scan(16'hFFFF, 32'd100);
      send_scan(16'hFFFF, 32'd150);
      send_scan(16'h0000, 32'd1200);
      // release with nothing held
      send_scan(16'h0000, 32'd1300);
      // single then double tap on the top pad
      send_scan(16'h8000, 32'd2000);
      send_scan(16'h0000, 32'd2050);
      send_scan(16'h8000, 32'd2100);
      send_scan(16'h0000, 32'd2150);
      // hold between the thresholds
      send_scan(16'h0008, 32'd3000);
      send_scan(16'h0000, 32'd3500);
      // holds right at and just under the thresholds
      send_scan(16'h0010, 32'd4000);
      send_scan(16'h0000, 32'd4200);
      send_scan(16'h0020, 32'd4300);
      send_scan(16'h0000, 32'd4499);
      send_scan(16'h0040, 32'd5000);
      send_scan(16'h0000, 32'd6000);
      // timestamp wraps during a tap
      send_scan(16'h0002, 32'hFFFF_FFF0);
      send_scan(16'h0000, 32'h0000_0010);
      // time running backwards gives a huge hold
      send_scan(16'h0004, 32'h0000_2000);
      send_scan(16'h0000, 32'h0000_1000);
      // all ones then all zeros
      send_scan(16'hFFFF, 32'hFFFF_FFFF);
      send_scan(16'h0000, 32'h0000_0000);
      settle();

      run_phase(SHORT_TAP_RESET, LONG_PRESS_RESET, DOUBLE_TAP_RESET, 90, 1'b1);
      run_phase(16'h0000, 16'h0000, 16'h0000, 80, 1'b0);
      run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 80, 1'b0);
      // short threshold above the long one
      run_phase(16'd700, 16'd150, 16'hFFFF, 80, 1'b1);
      run_phase(16'd1, 16'hFFFF, 16'h0000, 80, 1'b0);
      run_phase(THRESH_WIDTH'($urandom_range(0, 2000)), THRESH_WIDTH'($urandom_range(0, 3000)),
                THRESH_WIDTH'($urandom_range(0, 2000)), 90, 1'b0);

      repeat (5) @(posedge clock);
      if (failures == 0 && pending_words == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/ttg_pkg.sv
design/ttg_lane.sv
design/ttg_merge.sv
design/touch_tap_gesture_classifier.sv
bench/gesture_checker.sv
bench/testbench.sv
